/* src/tspsf_pkg.sv */
// Shared types and constants for the transport-stream packet sync framer.
package tspsf_pkg;

   localparam int WindowDepth   = 2048;
   localparam int WinAddrBits   = $clog2(WindowDepth);
   localparam int FillBits      = WinAddrBits + 1;
   localparam int MaxPacketSize = 255;
   localparam int MaxSyncCount  = 8;
   localparam int MinSyncCount  = 2;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);

   localparam logic [7:0] SYNC_WORD = 8'h47;

   localparam logic ACT_DATA  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   localparam logic CSR_PACKET_SIZE  = 1'b0;
   localparam logic CSR_SYNC_PACKETS = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       packet_first;
      logic       packet_last;
      logic       sync_gained;
      logic       sync_dropped;
      logic       window_empty;
   } result_type;

endpackage

/* src/tspsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tspsf_ram #(
   parameter int Width = 8,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/tspsf_front.sv */
// Input queue that accepts stream transactions and hands them to the framing engine.
module tspsf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tspsf_pkg::item_type item,
   output logic                deq_valid,
   input  logic                deq,
   output tspsf_pkg::item_type deq_item
);

   tspsf_pkg::item_type slot_ff [tspsf_pkg::QueueDepth];
   logic [tspsf_pkg::QueuePtrBits-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [tspsf_pkg::QueuePtrBits:0]   count_ff, count_in;
   logic                               do_push, do_pop;

   assign full      = count_ff == (tspsf_pkg::QueuePtrBits+1)'(tspsf_pkg::QueueDepth);
   assign deq_valid = count_ff != '0;
   assign deq_item  = slot_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = deq && deq_valid;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= item;
      end
   end

endmodule

/* src/tspsf_back.sv */
// Framing engine: lookahead window, sync search sequencer and result register.
module tspsf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  item_valid,
   output logic                  item_take,
   input  tspsf_pkg::item_type   item,
   output logic                  res_full,
   input  logic                  res_pop,
   output tspsf_pkg::result_type res
);

   localparam int AW = tspsf_pkg::WinAddrBits;
   localparam int FW = tspsf_pkg::FillBits;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;

   logic [7:0]  psize_ff;
   logic [3:0]  nsync_ff;
   logic [1:0]  state_ff, state_in;
   logic        act_ff, act_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] head_ff, head_in;
   logic [7:0]  rem_ff, rem_in;
   logic        locked_ff, locked_in, ds_ff, ds_in;
   logic [3:0]  k_ff, k_in;
   logic [FW:0] off_ff, off_in;
   logic [7:0]  byte0_ff, byte0_in;
   logic        res_full_ff, res_full_in;
   tspsf_pkg::result_type res_ff, res_in;

   logic        we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]  rdata, b0;
   logic [11:0] prod;
   logic [FW:0] span_raw, span;
   logic        done, emit, start, drop_pop;
   logic [3:0]  k_next;
   logic [FW:0] off_next;
   logic [7:0]  rem_new;
   logic [FW-1:0] fill_after;

   tspsf_ram #(.Width(8), .Depth(tspsf_pkg::WindowDepth)) u_window (
      .clock(clock), .we(we), .waddr(waddr), .wdata(item.in_byte),
      .re(re), .raddr(raddr), .rdata(rdata)
   );

   assign prod     = 12'(nsync_ff - 4'd1) * 12'(psize_ff);
   assign span_raw = (FW+1)'(prod) + 1'b1;
   assign span     = (span_raw > (FW+1)'(tspsf_pkg::WindowDepth)) ?
                     (FW+1)'(tspsf_pkg::WindowDepth) : span_raw;

   assign item_take = (state_ff == ST_IDLE) && item_valid && !res_full_ff;
   assign we    = item_take && item.action == tspsf_pkg::ACT_DATA &&
                  fill_ff < FW'(tspsf_pkg::WindowDepth);
   assign waddr = head_ff + fill_ff[AW-1:0];
   assign re    = state_ff == ST_READ;
   assign raddr = head_ff + off_ff[AW-1:0];
   assign b0    = (k_ff == '0) ? rdata : byte0_ff;
   assign k_next   = k_ff + 1'b1;
   assign off_next = off_ff + (FW+1)'(psize_ff);
   assign res_full = res_full_ff;
   assign res      = res_ff;

   always_comb begin
      state_in = state_ff; act_in = act_ff; fill_in = fill_ff; head_in = head_ff;
      rem_in = rem_ff; locked_in = locked_ff; ds_in = ds_ff; k_in = k_ff;
      off_in = off_ff; byte0_in = byte0_ff;
      res_full_in = res_full_ff && !res_pop; res_in = res_ff;
      done = 1'b0; emit = 1'b0; start = 1'b0; drop_pop = 1'b0;
      rem_new = '0; fill_after = fill_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_take) begin
               act_in = item.action;
               k_in   = '0;
               off_in = '0;
               if (item.action == tspsf_pkg::ACT_DATA) begin
                  ds_in = 1'b0;
                  if (we) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (act_ff == tspsf_pkg::ACT_DATA) begin
               if ((FW+1)'(fill_ff) < span) begin
                  done = 1'b1;
               end else if (rem_ff != '0) begin
                  done = 1'b1; emit = 1'b1;
               end else if (rdata != tspsf_pkg::SYNC_WORD) begin
                  done = 1'b1; drop_pop = 1'b1;
               end else if (k_next >= nsync_ff || off_next >= (FW+1)'(fill_ff)) begin
                  done = 1'b1; emit = 1'b1; start = 1'b1;
               end else begin
                  byte0_in = b0;
                  k_in     = k_next;
                  off_in   = off_next;
                  state_in = ST_READ;
               end
            end else begin
               done = 1'b1;
               if (fill_ff != '0) begin
                  if (rem_ff != '0) begin
                     emit = 1'b1;
                  end else if (!ds_ff && locked_ff && fill_ff >= FW'(psize_ff) &&
                               b0 == tspsf_pkg::SYNC_WORD) begin
                     emit = 1'b1; start = 1'b1;
                  end else begin
                     ds_in = 1'b1; drop_pop = 1'b1;
                  end
               end
            end

            if (done) begin
               state_in = ST_IDLE;
               rem_new  = start ? psize_ff - 1'b1 : rem_ff - 1'b1;
               if (emit || drop_pop) begin
                  head_in    = head_ff + 1'b1;
                  fill_after = fill_ff - 1'b1;
               end
               fill_in = fill_after;
               if (emit) begin
                  rem_in = rem_new;
               end
               res_in = '0;
               res_in.out_valid    = emit;
               res_in.out_byte     = emit ? b0 : 8'd0;
               res_in.packet_first = start;
               res_in.packet_last  = emit && rem_new == '0;
               res_in.window_empty = fill_after == '0;
               if (act_ff == tspsf_pkg::ACT_DATA) begin
                  if (start) begin
                     res_in.sync_gained = !locked_ff;
                     locked_in = 1'b1;
                  end else if (drop_pop) begin
                     res_in.sync_dropped = locked_ff;
                     locked_in = 1'b0;
                  end
               end else if (fill_after == '0) begin
                  rem_in = '0;
                  ds_in  = 1'b0;
               end
               res_full_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff    <= 8'd188;
         nsync_ff    <= 4'd2;
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         head_ff     <= '0;
         rem_ff      <= '0;
         locked_ff   <= 1'b0;
         ds_ff       <= 1'b0;
         res_full_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == tspsf_pkg::CSR_PACKET_SIZE && csr_wdata != 8'd0 &&
             32'(csr_wdata) <= tspsf_pkg::MaxPacketSize) begin
            psize_ff <= csr_wdata;
         end
         if (csr_we && csr_index == tspsf_pkg::CSR_SYNC_PACKETS &&
             32'(csr_wdata[3:0]) >= tspsf_pkg::MinSyncCount &&
             32'(csr_wdata[3:0]) <= tspsf_pkg::MaxSyncCount) begin
            nsync_ff <= csr_wdata[3:0];
         end
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         rem_ff      <= rem_in;
         locked_ff   <= locked_in;
         ds_ff       <= ds_in;
         res_full_ff <= res_full_in;
      end
      act_ff   <= act_in;
      k_ff     <= k_in;
      off_ff   <= off_in;
      byte0_ff <= byte0_in;
      res_ff   <= res_in;
   end

endmodule

/* src/ts_packet_sync_framer_core.sv */
// Top level of the transport-stream packet sync framer.
// This block frames transport-stream packets from a byte stream. Each input transaction is
// either a data byte or a drain request, and each one yields exactly one result transaction
// carrying at most one emitted packet byte plus the sync_gained, sync_dropped and window_empty
// flags. Bytes are held in a 2048-byte lookahead window; a data byte starts a packet only when the
// bytes at every packet_size spacing, for sync_packets - 1 further packets, are also 0x47, while a
// locked drain starts one at a 0x47 when a full packet is still held. A transaction passes through
// the idle, read and check states of the framing engine and goes back through read and check for
// every further sync position that is checked, since the single read port of the window memory is
// visited once per checked position. A four-entry input queue keeps accepting transactions while
// the engine works or a result waits to be popped. Configuration writes take effect at once and
// must only be issued while the block is idle. No clearing pass is needed after reset.
module ts_packet_sync_framer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_action,
   input  logic [7:0] req_in_byte,
   output logic       empty,
   input  logic       pop,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_packet_first,
   output logic       rsp_packet_last,
   output logic       rsp_sync_gained,
   output logic       rsp_sync_dropped,
   output logic       rsp_window_empty,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   tspsf_pkg::item_type   in_item, q_item;
   tspsf_pkg::result_type res;
   logic                  q_valid, q_take, res_full;

   // The input transaction is packed into one item for the queue.
   assign in_item.action  = req_action;
   assign in_item.in_byte = req_in_byte;

   tspsf_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .item(in_item),
      .deq_valid(q_valid), .deq(q_take), .deq_item(q_item)
   );

   // The engine pops the queue only when its result register is free.
   tspsf_back u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .item_valid(q_valid), .item_take(q_take), .item(q_item),
      .res_full(res_full), .res_pop(pop), .res(res)
   );

   assign empty            = !res_full;
   assign rsp_out_valid    = res.out_valid;
   assign rsp_out_byte     = res.out_byte;
   assign rsp_packet_first = res.packet_first;
   assign rsp_packet_last  = res.packet_last;
   assign rsp_sync_gained  = res.sync_gained;
   assign rsp_sync_dropped = res.sync_dropped;
   assign rsp_window_empty = res.window_empty;

endmodule

/* src/tspsf_checker.sv */
// Port-level checker for the framer, bound to the top level.
module tspsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_first,
   input logic       rsp_sync_gained,
   input logic       rsp_sync_dropped
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_first_is_valid: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_packet_first) |-> rsp_out_valid)
      else $error("packet start without a byte");

   a_first_is_sync: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_packet_first) |-> rsp_out_byte == tspsf_pkg::SYNC_WORD)
      else $error("packet start is not a sync byte");

   a_gain_starts_packet: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_sync_gained) |-> rsp_packet_first)
      else $error("lock gained without a packet start");

   a_gain_drop_exclusive: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_sync_gained && rsp_sync_dropped))
      else $error("lock gained and lost together");

endmodule

bind ts_packet_sync_framer_core tspsf_checker u_tspsf_checker (
   .clock(clock), .reset(reset), .empty(empty), .rsp_out_valid(rsp_out_valid),
   .rsp_out_byte(rsp_out_byte), .rsp_packet_first(rsp_packet_first),
   .rsp_sync_gained(rsp_sync_gained), .rsp_sync_dropped(rsp_sync_dropped)
);
